>>> design/plcc_pkg.sv
`default_nettype none

package plcc_pkg;

    typedef logic [3:0]  t_step;
    typedef logic [24:0] t_color;

    localparam t_step STEP_BRIGHT     = 4'd0;
    localparam t_step STEP_BRIGHT_DIV = 4'd1;
    localparam t_step STEP_VALUE      = 4'd2;
    localparam t_step STEP_VALUE_DIV  = 4'd3;
    localparam t_step STEP_VAL        = 4'd4;
    localparam t_step STEP_SAT        = 4'd5;
    localparam t_step STEP_REM        = 4'd6;
    localparam t_step STEP_X1         = 4'd7;
    localparam t_step STEP_X2         = 4'd8;
    localparam t_step STEP_P          = 4'd9;
    localparam t_step STEP_Q          = 4'd10;
    localparam t_step STEP_T          = 4'd11;
    localparam t_step STEP_DRAIN      = 4'd12;
    localparam t_step STEP_NONE       = 4'd15;

    localparam logic OP_KEY_EVENT = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    localparam int OPA_W  = 14;
    localparam int OPB_W  = 23;
    localparam int PROD_W = 29;

    // Reciprocal constants: x / 100 is (x * 5243) >> 19 for x below 32768, and
    // x / 60 is (x * 17477) >> 20 for x below 16384. The *255 factors are folded in.
    localparam logic [OPB_W-1:0] RECIP_100     = 23'd5243;
    localparam logic [OPB_W-1:0] RECIP_255_100 = 23'd1336965;
    localparam logic [OPB_W-1:0] RECIP_255_60  = 23'd4456635;

    typedef struct packed {
        logic  accept;
        logic  mul_en;
        t_step step;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic pixel;
        logic blank;
        logic out_free;
    } t_status;

    function automatic logic [6:0] cap100(input logic [7:0] x);
        cap100 = (x > 8'd100) ? 7'd100 : x[6:0];
    endfunction

    // Exact floor(x / 255) for x below 65280, which covers any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        div255 = sum[15:8];
    endfunction

endpackage

`default_nettype wire

>>> design/plcc_ctrl.sv
`default_nettype none

module plcc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire plcc_pkg::t_status i_status,
    output logic                   o_in_stall,
    output plcc_pkg::t_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]      r_state, n_state;
    plcc_pkg::t_step r_step, n_step;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.step     = plcc_pkg::STEP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.pixel) begin
                        n_step  = plcc_pkg::STEP_BRIGHT;
                        n_state = i_status.blank ? ST_DONE : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step   = r_step;
                o_cmd.mul_en = (r_step != plcc_pkg::STEP_DRAIN);
                if (r_step == plcc_pkg::STEP_DRAIN) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = plcc_pkg::t_step'(r_step + 4'd1);
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= plcc_pkg::STEP_BRIGHT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> design/plcc_datapath.sv
`default_nettype none

module plcc_datapath #(
    parameter int KEY_POSITIONS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire plcc_pkg::t_cmd   i_cmd,
    output plcc_pkg::t_status     o_status,
    input  wire logic             i_operation,
    input  wire logic [7:0]       i_key_position,
    input  wire logic             i_key_down,
    input  wire logic             i_led_is_underglow,
    input  wire logic             i_system_active,
    input  wire plcc_pkg::t_color i_default_color,
    input  wire plcc_pkg::t_color i_underglow_color,
    input  wire plcc_pkg::t_color i_pressed_color,
    input  wire logic             i_pressed_enable,
    input  wire logic [6:0]       i_brightness,
    input  wire logic [6:0]       i_brightness_max,
    input  wire logic             i_led_on,
    input  wire logic             i_auto_off_idle,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);

    localparam int KW = (KEY_POSITIONS > 1) ? $clog2(KEY_POSITIONS) : 1;
    localparam logic [7:0] KEY_POS_LIM = 8'(KEY_POSITIONS);

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    logic [KEY_POSITIONS-1:0] r_map;
    logic                     in_range;
    logic [KW-1:0]            key_idx;
    logic                     pressed;
    plcc_pkg::t_color         sel_color;

    logic [8:0]  r_hue;
    logic [6:0]  r_s, r_v;
    logic        r_blank;

    logic [plcc_pkg::OPA_W-1:0] opa;
    logic [plcc_pkg::OPB_W-1:0] opb;
    logic [plcc_pkg::OPA_W+plcc_pkg::OPB_W-1:0] mul_full;
    logic [plcc_pkg::PROD_W-1:0] r_prod;
    plcc_pkg::t_step r_cap_step;

    logic [7:0] r_val, r_sat, r_rem, r_x1, r_x2, r_p, r_q, r_t;
    logic [6:0] bc, mc;
    logic [8:0] hue_w;
    logic [2:0] sector;
    logic [8:0] sector_base;
    logic [5:0] rem_raw;
    logic [7:0] red_c, green_c, blue_c;

    logic       r_out_valid;
    logic [7:0] r_red, r_green, r_blue;

    assign in_range  = (i_key_position < KEY_POS_LIM);
    assign key_idx   = i_key_position[KW-1:0];
    assign pressed   = in_range && r_map[key_idx];
    assign sel_color = i_led_is_underglow ? i_underglow_color :
                       (i_pressed_enable && pressed) ? i_pressed_color : i_default_color;

    assign o_status.pixel    = (i_operation == plcc_pkg::OP_PIXEL);
    assign o_status.blank    = !i_led_on || (i_auto_off_idle && !i_system_active);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.accept && (i_operation == plcc_pkg::OP_KEY_EVENT) && in_range) begin
            r_map[key_idx] <= i_key_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hue   <= sel_color[24:16];
            r_s     <= plcc_pkg::cap100(sel_color[15:8]);
            r_v     <= plcc_pkg::cap100(sel_color[7:0]);
            r_blank <= o_status.blank;
        end
    end

    assign bc = plcc_pkg::cap100({1'b0, i_brightness});
    assign mc = plcc_pkg::cap100({1'b0, i_brightness_max});

    always_comb begin
        hue_w = (r_hue >= 9'd360) ? (r_hue - 9'd360) : r_hue;
        if (hue_w >= 9'd300) begin
            sector = SECTOR_5; sector_base = 9'd300;
        end else if (hue_w >= 9'd240) begin
            sector = SECTOR_4; sector_base = 9'd240;
        end else if (hue_w >= 9'd180) begin
            sector = SECTOR_3; sector_base = 9'd180;
        end else if (hue_w >= 9'd120) begin
            sector = SECTOR_2; sector_base = 9'd120;
        end else if (hue_w >= 9'd60) begin
            sector = SECTOR_1; sector_base = 9'd60;
        end else begin
            sector = SECTOR_0; sector_base = 9'd0;
        end
        rem_raw = 6'(hue_w - sector_base);
    end

    always_comb begin
        opa = '0;
        opb = '0;
        case (i_cmd.step)
            plcc_pkg::STEP_BRIGHT: begin
                opa = {7'b0, bc};
                opb = {16'b0, mc};
            end
            plcc_pkg::STEP_BRIGHT_DIV, plcc_pkg::STEP_VALUE_DIV: begin
                opa = r_prod[13:0];
                opb = plcc_pkg::RECIP_100;
            end
            plcc_pkg::STEP_VALUE: begin
                opa = {7'b0, r_v};
                opb = {16'b0, r_prod[25:19]};
            end
            plcc_pkg::STEP_VAL: begin
                opa = {7'b0, r_prod[25:19]};
                opb = plcc_pkg::RECIP_255_100;
            end
            plcc_pkg::STEP_SAT: begin
                opa = {7'b0, r_s};
                opb = plcc_pkg::RECIP_255_100;
            end
            plcc_pkg::STEP_REM: begin
                opa = {8'b0, rem_raw};
                opb = plcc_pkg::RECIP_255_60;
            end
            plcc_pkg::STEP_X1: begin
                opa = {6'b0, r_sat};
                opb = {15'b0, r_prod[27:20]};
            end
            plcc_pkg::STEP_X2: begin
                opa = {6'b0, r_sat};
                opb = {15'b0, 8'd255 - r_rem};
            end
            plcc_pkg::STEP_P: begin
                opa = {6'b0, r_val};
                opb = {15'b0, 8'd255 - r_sat};
            end
            plcc_pkg::STEP_Q: begin
                opa = {6'b0, r_val};
                opb = {15'b0, 8'd255 - r_x1};
            end
            plcc_pkg::STEP_T: begin
                opa = {6'b0, r_val};
                opb = {15'b0, 8'd255 - r_x2};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign mul_full = opa * opb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_full[plcc_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_step <= plcc_pkg::STEP_NONE;
        end else begin
            r_cap_step <= i_cmd.mul_en ? i_cmd.step : plcc_pkg::STEP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cap_step)
            plcc_pkg::STEP_VAL: r_val <= r_prod[26:19];
            plcc_pkg::STEP_SAT: r_sat <= r_prod[26:19];
            plcc_pkg::STEP_REM: r_rem <= r_prod[27:20];
            plcc_pkg::STEP_X1:  r_x1  <= plcc_pkg::div255(r_prod[15:0]);
            plcc_pkg::STEP_X2:  r_x2  <= plcc_pkg::div255(r_prod[15:0]);
            plcc_pkg::STEP_P:   r_p   <= plcc_pkg::div255(r_prod[15:0]);
            plcc_pkg::STEP_Q:   r_q   <= plcc_pkg::div255(r_prod[15:0]);
            plcc_pkg::STEP_T:   r_t   <= plcc_pkg::div255(r_prod[15:0]);
            default: begin
            end
        endcase
    end

    always_comb begin
        case (sector)
            SECTOR_0: begin red_c = r_val; green_c = r_t;   blue_c = r_p;   end
            SECTOR_1: begin red_c = r_q;   green_c = r_val; blue_c = r_p;   end
            SECTOR_2: begin red_c = r_p;   green_c = r_val; blue_c = r_t;   end
            SECTOR_3: begin red_c = r_p;   green_c = r_q;   blue_c = r_val; end
            SECTOR_4: begin red_c = r_t;   green_c = r_p;   blue_c = r_val; end
            default:  begin red_c = r_val; green_c = r_p;   blue_c = r_q;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_red   <= r_blank ? 8'd0 : red_c;
            r_green <= r_blank ? 8'd0 : green_c;
            r_blue  <= r_blank ? 8'd0 : blue_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule

`default_nettype wire

>>> design/perkey_led_color_compositor_unit.sv
// Key events update the key map and the block can take the next transaction right after.
// A pixel transaction runs its chain of steps on one shared multiplier, then loads the
// output register once it is free; a blanked pixel skips the multiplier steps.
// The input is stalled until the pixel's result is loaded, so pixels do not overlap.
// Synchronous active-low reset clears the key map and the handshake state and loads
// the register defaults (brightness 100, maximum 100, LEDs on).
`default_nettype none

module perkey_led_color_compositor_unit #(
    parameter int KEY_POSITIONS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_key_position,
    input  wire logic        i_key_down,
    input  wire logic        i_led_is_underglow,
    input  wire logic        i_system_active,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] REG_DEFAULT_COLOR   = 3'd0;
    localparam logic [2:0] REG_UNDERGLOW_COLOR = 3'd1;
    localparam logic [2:0] REG_PRESSED_COLOR   = 3'd2;
    localparam logic [2:0] REG_PRESSED_ENABLE  = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS      = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS_MAX  = 3'd5;
    localparam logic [2:0] REG_LED_ON          = 3'd6;
    localparam logic [2:0] REG_AUTO_OFF_IDLE   = 3'd7;

    plcc_pkg::t_color r_default_color, r_underglow_color, r_pressed_color;
    logic             r_pressed_enable, r_led_on, r_auto_off_idle;
    logic [6:0]       r_brightness, r_brightness_max;
    logic             cfg_write;
    logic [2:0]       reg_idx;

    plcc_pkg::t_cmd    cmd;
    plcc_pkg::t_status status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color   <= '0;
            r_underglow_color <= '0;
            r_pressed_color   <= '0;
            r_pressed_enable  <= 1'b0;
            r_brightness      <= 7'd100;
            r_brightness_max  <= 7'd100;
            r_led_on          <= 1'b1;
            r_auto_off_idle   <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_DEFAULT_COLOR:   r_default_color   <= pwdata[24:0];
                REG_UNDERGLOW_COLOR: r_underglow_color <= pwdata[24:0];
                REG_PRESSED_COLOR:   r_pressed_color   <= pwdata[24:0];
                REG_PRESSED_ENABLE:  r_pressed_enable  <= pwdata[0];
                REG_BRIGHTNESS:      r_brightness      <= pwdata[6:0];
                REG_BRIGHTNESS_MAX:  r_brightness_max  <= pwdata[6:0];
                REG_LED_ON:          r_led_on          <= pwdata[0];
                REG_AUTO_OFF_IDLE:   r_auto_off_idle   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEFAULT_COLOR:   prdata = {7'b0, r_default_color};
            REG_UNDERGLOW_COLOR: prdata = {7'b0, r_underglow_color};
            REG_PRESSED_COLOR:   prdata = {7'b0, r_pressed_color};
            REG_PRESSED_ENABLE:  prdata = {31'b0, r_pressed_enable};
            REG_BRIGHTNESS:      prdata = {25'b0, r_brightness};
            REG_BRIGHTNESS_MAX:  prdata = {25'b0, r_brightness_max};
            REG_LED_ON:          prdata = {31'b0, r_led_on};
            REG_AUTO_OFF_IDLE:   prdata = {31'b0, r_auto_off_idle};
            default:             prdata = '0;
        endcase
    end

    plcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    plcc_datapath #(
        .KEY_POSITIONS (KEY_POSITIONS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_operation        (i_operation),
        .i_key_position     (i_key_position),
        .i_key_down         (i_key_down),
        .i_led_is_underglow (i_led_is_underglow),
        .i_system_active    (i_system_active),
        .i_default_color    (r_default_color),
        .i_underglow_color  (r_underglow_color),
        .i_pressed_color    (r_pressed_color),
        .i_pressed_enable   (r_pressed_enable),
        .i_brightness       (r_brightness),
        .i_brightness_max   (r_brightness_max),
        .i_led_on           (r_led_on),
        .i_auto_off_idle    (r_auto_off_idle),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue)
    );

endmodule

`default_nettype wire

>>> design/plcc_checker.sv
`default_nettype none

module plcc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_operation,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue
);

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation == plcc_pkg::OP_PIXEL) |=> o_in_stall)
        else $error("pixel transaction did not hold off the input");

    a_key_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation == plcc_pkg::OP_KEY_EVENT) |=> !o_in_stall)
        else $error("key event transaction stalled the input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue)))
        else $error("stalled result changed or dropped");

    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pixel in progress");

endmodule

bind perkey_led_color_compositor_unit plcc_checker u_plcc_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;

    localparam int KEY_SLOTS = 64;

    localparam int REG_DEFAULT_COLOR   = 0;
    localparam int REG_UNDERGLOW_COLOR = 1;
    localparam int REG_PRESSED_COLOR   = 2;
    localparam int REG_PRESSED_ENABLE  = 3;
    localparam int REG_BRIGHTNESS      = 4;
    localparam int REG_BRIGHTNESS_MAX  = 5;
    localparam int REG_LED_ON          = 6;
    localparam int REG_AUTO_OFF_IDLE   = 7;

    typedef struct {
        logic       op;
        logic [7:0] pos;
        logic       down;
        logic       underglow;
        logic       active;
    } t_led_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid = 1'b0;
    logic        i_operation = 1'b0;
    logic [7:0]  i_key_position = 8'd0;
    logic        i_key_down = 1'b0;
    logic        i_led_is_underglow = 1'b0;
    logic        i_system_active = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic [7:0]  o_red;
    wire logic [7:0]  o_green;
    wire logic [7:0]  o_blue;
    wire logic [31:0] prdata;
    wire logic        pready;

    perkey_led_color_compositor_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_key_position     (i_key_position),
        .i_key_down         (i_key_down),
        .i_led_is_underglow (i_led_is_underglow),
        .i_system_active    (i_system_active),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #5 i_clk = ~i_clk;

    // Register mirror and key map.
    plcc_pkg::t_color dflt_color_m;
    plcc_pkg::t_color glow_color_m;
    plcc_pkg::t_color press_color_m;
    logic        press_en_m;
    logic [6:0]  bright_m;
    logic [6:0]  bright_max_m;
    logic        led_on_m;
    logic        auto_off_m;
    logic [63:0] key_map;

    t_led_req pending[$];
    t_rgb     expected_rgb[$];
    t_led_req cur;
    bit       offering = 1'b0;
    bit       in_fire = 1'b0;
    bit       calm = 1'b0;
    bit       sink_hold = 1'b0;
    bit       hold_go = 1'b0;
    int       src_gap = 0;
    int       sink_gap = 0;
    int       errors = 0;

    function automatic int unsigned pct_limit(int unsigned x);
        return (x > 100) ? 100 : x;
    endfunction

    function automatic t_rgb shade_pixel(logic [7:0] pos, logic underglow, logic active);
        int unsigned scale, hue, s, v, val, sat, h, region, rem, p, q, t;
        plcc_pkg::t_color color;
        t_rgb px;
        if (!led_on_m || (auto_off_m && !active)) return '0;
        scale = pct_limit(bright_m) * pct_limit(bright_max_m) / 100;
        if (underglow) begin
            color = glow_color_m;
        end else if (press_en_m && pos < KEY_SLOTS && key_map[pos[5:0]]) begin
            color = press_color_m;
        end else begin
            color = dflt_color_m;
        end
        hue = color[24:16];
        s = pct_limit(color[15:8]);
        v = pct_limit(color[7:0]);
        val = (v * scale / 100) * 255 / 100;
        sat = s * 255 / 100;
        if (sat == 0) return {val[7:0], val[7:0], val[7:0]};
        h = hue % 360;
        region = h / 60;
        rem = (h % 60) * 255 / 60;
        p = val * (255 - sat) / 255;
        q = val * (255 - sat * rem / 255) / 255;
        t = val * (255 - sat * (255 - rem) / 255) / 255;
        case (region)
            0: px = {val[7:0], t[7:0], p[7:0]};
            1: px = {q[7:0], val[7:0], p[7:0]};
            2: px = {p[7:0], val[7:0], t[7:0]};
            3: px = {p[7:0], q[7:0], val[7:0]};
            4: px = {t[7:0], p[7:0], val[7:0]};
            default: px = {val[7:0], p[7:0], q[7:0]};
        endcase
        return px;
    endfunction

    function automatic t_led_req make_req(logic op, logic [7:0] pos, logic down,
                                          logic underglow, logic active);
        t_led_req r;
        r.op = op;
        r.pos = pos;
        r.down = down;
        r.underglow = underglow;
        r.active = active;
        return r;
    endfunction

    function automatic logic [31:0] hsv_word(int hue, int sat, int val);
        return {7'd0, hue[8:0], sat[7:0], val[7:0]};
    endfunction

    function automatic int pick_hue();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 359;
            2: return $urandom_range(360, 511);
            default: return $urandom_range(0, 359);
        endcase
    endfunction

    function automatic int pick_pct(int top);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 100;
            2: return $urandom_range(101, top);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    task automatic write_reg(int idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 5'(idx * 4);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DEFAULT_COLOR:   dflt_color_m = value[24:0];
            REG_UNDERGLOW_COLOR: glow_color_m = value[24:0];
            REG_PRESSED_COLOR:   press_color_m = value[24:0];
            REG_PRESSED_ENABLE:  press_en_m = value[0];
            REG_BRIGHTNESS:      bright_m = value[6:0];
            REG_BRIGHTNESS_MAX:  bright_max_m = value[6:0];
            REG_LED_ON:          led_on_m = value[0];
            REG_AUTO_OFF_IDLE:   auto_off_m = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits until every transaction is through and the block has gone quiet.
    task automatic settle();
        while (pending.size() != 0 || offering || expected_rgb.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb want;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            if (i_operation == plcc_pkg::OP_PIXEL) begin
                expected_rgb.push_back(shade_pixel(i_key_position, i_led_is_underglow,
                                                   i_system_active));
            end else if (i_key_position < KEY_SLOTS) begin
                key_map[i_key_position[5:0]] = i_key_down;
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d",
                         $time, o_red, o_green, o_blue);
                errors++;
            end else begin
                want = expected_rgb.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
            end
        end
    end

    always @(negedge i_clk) begin
        if (in_fire) offering = 1'b0;
        if (!offering) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending.size() != 0) begin
                if (!calm && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 13);
                end else begin
                    cur = pending.pop_front();
                    offering = 1'b1;
                end
            end
        end
        i_in_valid <= offering;
        i_operation <= cur.op;
        i_key_position <= cur.pos;
        i_key_down <= cur.down;
        i_led_is_underglow <= cur.underglow;
        i_system_active <= cur.active;
    end

    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(1, 13);
        end
        i_out_stall <= sink_hold || sink_gap > 0;
    end

    initial begin
        wait (hold_go);
        sink_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_led_req r;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        dflt_color_m = '0;
        glow_color_m = '0;
        press_color_m = '0;
        press_en_m = 1'b0;
        bright_m = 7'd100;
        bright_max_m = 7'd100;
        led_on_m = 1'b1;
        auto_off_m = 1'b0;
        key_map = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd5, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd5, 1'b0, 1'b1, 1'b0));
        settle();

        write_reg(REG_DEFAULT_COLOR, hsv_word(0, 100, 100));
        write_reg(REG_UNDERGLOW_COLOR, hsv_word(120, 0, 50));
        write_reg(REG_PRESSED_COLOR, hsv_word(240, 100, 100));
        write_reg(REG_PRESSED_ENABLE, 32'd1);
        pending.push_back(make_req(plcc_pkg::OP_KEY_EVENT, 8'd0, 1'b1, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_KEY_EVENT, 8'd63, 1'b1, 1'b1, 1'b0));
        pending.push_back(make_req(plcc_pkg::OP_KEY_EVENT, 8'd64, 1'b1, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_KEY_EVENT, 8'd255, 1'b1, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd0, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd63, 1'b1, 1'b0, 1'b0));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd64, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd255, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd0, 1'b0, 1'b1, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_KEY_EVENT, 8'd0, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd0, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd1, 1'b0, 1'b0, 1'b1));
        settle();

        write_reg(REG_DEFAULT_COLOR, hsv_word(359, 255, 255));
        write_reg(REG_UNDERGLOW_COLOR, hsv_word(360, 50, 100));
        write_reg(REG_PRESSED_COLOR, hsv_word(511, 1, 1));
        write_reg(REG_BRIGHTNESS, 32'd127);
        write_reg(REG_BRIGHTNESS_MAX, 32'd127);
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd2, 1'b0, 1'b0, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd2, 1'b0, 1'b1, 1'b1));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd63, 1'b0, 1'b0, 1'b1));
        settle();

        write_reg(REG_LED_ON, 32'd0);
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd63, 1'b0, 1'b0, 1'b1));
        settle();

        write_reg(REG_LED_ON, 32'd1);
        write_reg(REG_AUTO_OFF_IDLE, 32'd1);
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd63, 1'b0, 1'b0, 1'b0));
        pending.push_back(make_req(plcc_pkg::OP_PIXEL, 8'd63, 1'b0, 1'b0, 1'b1));
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph >= 10);
            write_reg(REG_DEFAULT_COLOR, hsv_word(pick_hue(), pick_pct(255), pick_pct(255)));
            write_reg(REG_UNDERGLOW_COLOR, hsv_word(pick_hue(), pick_pct(255), pick_pct(255)));
            write_reg(REG_PRESSED_COLOR, hsv_word(pick_hue(), pick_pct(255), pick_pct(255)));
            write_reg(REG_PRESSED_ENABLE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
            write_reg(REG_BRIGHTNESS, pick_pct(127));
            write_reg(REG_BRIGHTNESS_MAX, pick_pct(127));
            write_reg(REG_LED_ON, ($urandom_range(0, 7) != 0) ? 32'd1 : 32'd0);
            write_reg(REG_AUTO_OFF_IDLE, $urandom_range(0, 1));
            for (int k = 0; k < 85; k++) begin
                r.op = ($urandom_range(0, 9) < 4) ? plcc_pkg::OP_KEY_EVENT
                                                  : plcc_pkg::OP_PIXEL;
                r.pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 63));
                r.down = ($urandom_range(0, 4) < 3);
                r.underglow = ($urandom_range(0, 3) == 0);
                r.active = $urandom_range(0, 1);
                pending.push_back(r);
            end
            if (ph == 2) hold_go = 1'b1;
            settle();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
